### rtl/rgbhsv_pkg.sv
// ============================================================================
// RGB/HSV converter package
// Shared constants, command and register codes, and item types.
// ============================================================================
package rgbhsv_pkg;

   // Channel and hue formats.
   localparam int CHANNEL_BITS  = 8;
   localparam int HUE_FRAC_BITS = 4;
   localparam int HUE_BITS      = 9 + HUE_FRAC_BITS;
   localparam int CMAX          = (1 << CHANNEL_BITS) - 1;
   localparam int SEXT          = 60 << HUE_FRAC_BITS;
   localparam int FULL_TURN     = 360 << HUE_FRAC_BITS;
   localparam int SEXT_BITS     = $clog2(SEXT + 1);

   // Denominator of the q and t terms of the sector rule.
   localparam int DEN           = CMAX * SEXT;
   localparam int DEN_BITS      = $clog2(DEN + 1);

   // Gain registers, unsigned Q2.8.
   localparam int GAIN_BITS      = 10;
   localparam int GAIN_FRAC      = 8;
   localparam int SAT_GAIN_RESET = 384;
   localparam int VAL_GAIN_RESET = 205;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAT_GAIN = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VAL_GAIN = 4'd1;

   // Command codes.
   localparam int CMD_BITS = 2;
   localparam logic [CMD_BITS-1:0] CMD_TO_HSV = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_TO_RGB = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_ADJUST = 2'd2;

   // One accepted item as it enters the pipeline.
   typedef struct packed {
      logic [CMD_BITS-1:0]     cmd;
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
      logic [HUE_BITS-1:0]     hue;
      logic [CHANNEL_BITS-1:0] sat;
      logic [CHANNEL_BITS-1:0] val;
   } pixel_type;

   // Item leaving the RGB to HSV section.
   typedef struct packed {
      pixel_type               src;
      logic [HUE_BITS-1:0]     hue;
      logic [CHANNEL_BITS-1:0] sat;
      logic [CHANNEL_BITS-1:0] val;
   } hsv_item_type;

   // Item entering the HSV to RGB section: the HSV to convert plus the
   // HSV fields that are reported in the result.
   typedef struct packed {
      logic [CMD_BITS-1:0]     cmd;
      logic [HUE_BITS-1:0]     hue;
      logic [CHANNEL_BITS-1:0] sat;
      logic [CHANNEL_BITS-1:0] val;
      logic [HUE_BITS-1:0]     hue_res;
      logic [CHANNEL_BITS-1:0] sat_res;
      logic [CHANNEL_BITS-1:0] val_res;
   } rgb_req_type;

   // Finished result.
   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
      logic [HUE_BITS-1:0]     hue;
      logic [CHANNEL_BITS-1:0] sat;
      logic [CHANNEL_BITS-1:0] val;
   } rsp_type;

endpackage

### rtl/rgbhsv_div.sv
// ============================================================================
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, MSB first.
// ============================================================================
module rgbhsv_div #(
   parameter int NUM_BITS = 16,
   parameter int DEN_BITS = 8,
   parameter int QUO_BITS = 8
) (
   input  logic                clock,
   input  logic [NUM_BITS-1:0] num_in,
   input  logic [DEN_BITS-1:0] den_in,
   output logic [QUO_BITS-1:0] quo_out
);

   localparam int WORK_BITS = (NUM_BITS > DEN_BITS + QUO_BITS) ?
                              NUM_BITS : DEN_BITS + QUO_BITS;

   logic [WORK_BITS-1:0] rem_ff [QUO_BITS];
   logic [DEN_BITS-1:0]  den_ff [QUO_BITS];
   logic [QUO_BITS-1:0]  quo_ff [QUO_BITS];

   genvar k;
   for (k = 0; k < QUO_BITS; k++) begin : g_stage
      logic [WORK_BITS-1:0] rem_src;
      logic [DEN_BITS-1:0]  den_src;
      logic [QUO_BITS-1:0]  quo_src;
      logic [WORK_BITS-1:0] trial;
      logic                 take;

      if (k == 0) begin : g_first
         assign rem_src = WORK_BITS'(num_in);
         assign den_src = den_in;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      // The quotient is known to fit in QUO_BITS, so the shifted divisor
      // never overflows the working width.
      assign trial = WORK_BITS'(den_src) << (QUO_BITS - 1 - k);
      assign take  = (rem_src >= trial);

      always_ff @(posedge clock) begin
         rem_ff[k] <= take ? (rem_src - trial) : rem_src;
         den_ff[k] <= den_src;
         quo_ff[k] <= quo_src | (take ? (QUO_BITS'(1) << (QUO_BITS - 1 - k)) : '0);
      end
   end

   assign quo_out = quo_ff[QUO_BITS-1];

endmodule

### rtl/rgbhsv_to_hsv.sv
// ============================================================================
// RGB to HSV section
// Max/min and sector pick, scaled numerators, two dividers, hue assembly.
// ============================================================================
module rgbhsv_to_hsv (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     valid_in,
   input  rgbhsv_pkg::pixel_type    item_in,
   output logic                     valid_out,
   output rgbhsv_pkg::hsv_item_type item_out
);

   localparam int CB        = rgbhsv_pkg::CHANNEL_BITS;
   localparam int HB        = rgbhsv_pkg::HUE_BITS;
   localparam int QUO_BITS  = rgbhsv_pkg::SEXT_BITS;
   localparam int SNUM_BITS = 2 * CB;
   localparam int HNUM_BITS = CB + rgbhsv_pkg::SEXT_BITS;

   localparam logic [1:0] SEL_RED   = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE  = 2'd2;

   typedef struct packed {
      rgbhsv_pkg::pixel_type src;
      logic                  zero;
      logic [1:0]            sel;
      logic                  neg;
   } side_type;

   // Stage A: max, min, sector and difference.
   logic [CB-1:0] mx, mn, a_val, c_val;
   logic [1:0]    sel;

   always_comb begin
      mx = item_in.red;
      mn = item_in.red;
      if (item_in.green > mx) mx = item_in.green;
      if (item_in.blue  > mx) mx = item_in.blue;
      if (item_in.green < mn) mn = item_in.green;
      if (item_in.blue  < mn) mn = item_in.blue;
      priority if (item_in.red >= mx) begin
         sel = SEL_RED;   a_val = item_in.green; c_val = item_in.blue;
      end else if (item_in.green >= mx) begin
         sel = SEL_GREEN; a_val = item_in.blue;  c_val = item_in.red;
      end else begin
         sel = SEL_BLUE;  a_val = item_in.red;   c_val = item_in.green;
      end
   end

   logic          a_valid_ff;
   side_type      a_side_ff;
   logic [CB-1:0] a_max_ff, a_delta_ff, a_diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_side_ff.src  <= item_in;
      a_side_ff.zero <= (mx == mn);
      a_side_ff.sel  <= sel;
      a_side_ff.neg  <= (a_val < c_val);
      a_max_ff       <= mx;
      a_delta_ff     <= mx - mn;
      a_diff_ff      <= (a_val < c_val) ? (c_val - a_val) : (a_val - c_val);
   end

   // Stage B: numerators of saturation and hue offset.
   logic                 b_valid_ff;
   side_type             b_side_ff;
   logic [CB-1:0]        b_max_ff, b_delta_ff;
   logic [SNUM_BITS-1:0] b_snum_ff;
   logic [HNUM_BITS-1:0] b_hnum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_side_ff  <= a_side_ff;
      b_max_ff   <= a_max_ff;
      b_delta_ff <= a_delta_ff;
      b_snum_ff  <= SNUM_BITS'(a_delta_ff) * SNUM_BITS'(rgbhsv_pkg::CMAX);
      b_hnum_ff  <= HNUM_BITS'(a_diff_ff) * HNUM_BITS'(rgbhsv_pkg::SEXT);
   end

   // Dividers, with the side data delayed alongside.
   logic [QUO_BITS-1:0] sat_quo, hue_quo;

   rgbhsv_div #(
      .NUM_BITS (SNUM_BITS),
      .DEN_BITS (CB),
      .QUO_BITS (QUO_BITS)
   ) u_sat_div (
      .clock   (clock),
      .num_in  (b_snum_ff),
      .den_in  (b_max_ff),
      .quo_out (sat_quo)
   );

   rgbhsv_div #(
      .NUM_BITS (HNUM_BITS),
      .DEN_BITS (CB),
      .QUO_BITS (QUO_BITS)
   ) u_hue_div (
      .clock   (clock),
      .num_in  (b_hnum_ff),
      .den_in  (b_delta_ff),
      .quo_out (hue_quo)
   );

   logic     d_valid_ff [QUO_BITS];
   side_type d_side_ff  [QUO_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUO_BITS; i++) d_valid_ff[i] <= 1'b0;
      end else begin
         d_valid_ff[0] <= b_valid_ff;
         for (int i = 1; i < QUO_BITS; i++) d_valid_ff[i] <= d_valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      d_side_ff[0] <= b_side_ff;
      for (int i = 1; i < QUO_BITS; i++) d_side_ff[i] <= d_side_ff[i-1];
   end

   // Stage F: hue assembly. Only the red sector can wrap below zero.
   side_type      f_side;
   logic [HB-1:0] base, mag, hue;

   always_comb begin
      f_side = d_side_ff[QUO_BITS-1];
      mag    = HB'(hue_quo);
      unique case (f_side.sel)
         SEL_GREEN: base = HB'(2 * rgbhsv_pkg::SEXT);
         SEL_BLUE:  base = HB'(4 * rgbhsv_pkg::SEXT);
         default:   base = '0;
      endcase
      if (!f_side.neg) begin
         hue = base + mag;
      end else if (mag > base) begin
         hue = base + HB'(rgbhsv_pkg::FULL_TURN) - mag;
      end else begin
         hue = base - mag;
      end
   end

   logic                     f_valid_ff;
   rgbhsv_pkg::hsv_item_type f_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= d_valid_ff[QUO_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      f_item_ff.src <= f_side.src;
      f_item_ff.hue <= f_side.zero ? '0 : hue;
      f_item_ff.sat <= f_side.zero ? '0 : sat_quo[CB-1:0];
      f_item_ff.val <= f_side.src.red > f_side.src.green ?
                       (f_side.src.red > f_side.src.blue ? f_side.src.red : f_side.src.blue) :
                       (f_side.src.green > f_side.src.blue ? f_side.src.green : f_side.src.blue);
   end

   assign valid_out = f_valid_ff;
   assign item_out  = f_item_ff;

endmodule

### rtl/rgbhsv_to_rgb.sv
// ============================================================================
// HSV to RGB section
// Sector split, products, reciprocal multiplications, sector select.
// ============================================================================
module rgbhsv_to_rgb (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid_in,
   input  rgbhsv_pkg::rgb_req_type req_in,
   output logic                    valid_out,
   output rgbhsv_pkg::rsp_type     rsp_out
);

   localparam int CB        = rgbhsv_pkg::CHANNEL_BITS;
   localparam int HB        = rgbhsv_pkg::HUE_BITS;
   localparam int FB        = rgbhsv_pkg::SEXT_BITS;
   localparam int DB        = rgbhsv_pkg::DEN_BITS;
   localparam int NSECT     = ((1 << HB) - 1) / rgbhsv_pkg::SEXT;
   localparam int IDX_BITS  = $clog2(NSECT + 1);
   localparam int PNUM_BITS = 2 * CB;
   localparam int QNUM_BITS = CB + DB;

   // Constant divisions are a multiply by a rounded-up reciprocal and a
   // shift. With the shift at the numerator width plus the divisor width,
   // the reciprocal error stays below one quotient step for every
   // numerator that fits, so the truncated quotient is exact.
   localparam int P_SHIFT = PNUM_BITS + CB;
   localparam int Q_SHIFT = QNUM_BITS + DB;
   localparam int PW      = PNUM_BITS + PNUM_BITS + 2;
   localparam int QW      = QNUM_BITS + QNUM_BITS + 2;
   localparam longint unsigned P_RECIP =
      ((64'd1 << P_SHIFT) + rgbhsv_pkg::CMAX - 1) / rgbhsv_pkg::CMAX;
   localparam longint unsigned Q_RECIP =
      ((64'd1 << Q_SHIFT) + rgbhsv_pkg::DEN - 1) / rgbhsv_pkg::DEN;

   typedef struct packed {
      rgbhsv_pkg::rgb_req_type req;
      logic [2:0]              sector;
   } side_type;

   // Stage 1: sector index (wrapping modulo six) and fraction.
   logic [IDX_BITS-1:0] idx;
   logic [2:0]          sector;
   logic [HB-1:0]       f_full;

   always_comb begin
      idx = '0;
      for (int k = 1; k <= NSECT; k++) begin
         idx = idx + IDX_BITS'(req_in.hue >= HB'(k * rgbhsv_pkg::SEXT));
      end
      sector = (idx >= IDX_BITS'(6)) ? 3'(idx - IDX_BITS'(6)) : 3'(idx);
      f_full = req_in.hue - HB'(HB'(idx) * HB'(rgbhsv_pkg::SEXT));
   end

   logic          s1_valid_ff;
   side_type      s1_side_ff;
   logic [FB-1:0] s1_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_side_ff.req    <= req_in;
      s1_side_ff.sector <= sector;
      s1_f_ff           <= f_full[FB-1:0];
   end

   // Stage 2: f*s, (SEXT-f)*s and the p numerator.
   logic                 s2_valid_ff;
   side_type             s2_side_ff;
   logic [DB-1:0]        s2_fs_ff, s2_gs_ff;
   logic [PNUM_BITS-1:0] s2_pnum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_side_ff <= s1_side_ff;
      s2_fs_ff   <= DB'(s1_f_ff) * DB'(s1_side_ff.req.sat);
      s2_gs_ff   <= (DB'(rgbhsv_pkg::SEXT) - DB'(s1_f_ff)) * DB'(s1_side_ff.req.sat);
      s2_pnum_ff <= PNUM_BITS'(s1_side_ff.req.val) *
                    (PNUM_BITS'(rgbhsv_pkg::CMAX) - PNUM_BITS'(s1_side_ff.req.sat));
   end

   // Stage 3: q and t numerators.
   logic                 s3_valid_ff;
   side_type             s3_side_ff;
   logic [QNUM_BITS-1:0] s3_qnum_ff, s3_tnum_ff;
   logic [PNUM_BITS-1:0] s3_pnum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_side_ff <= s2_side_ff;
      s3_pnum_ff <= s2_pnum_ff;
      s3_qnum_ff <= QNUM_BITS'(s2_side_ff.req.val) *
                    QNUM_BITS'(DB'(rgbhsv_pkg::DEN) - s2_fs_ff);
      s3_tnum_ff <= QNUM_BITS'(s2_side_ff.req.val) *
                    QNUM_BITS'(DB'(rgbhsv_pkg::DEN) - s2_gs_ff);
   end

   // Stage 4: reciprocal products for p, q and t.
   logic          s4_valid_ff;
   side_type      s4_side_ff;
   logic [PW-1:0] s4_pprod_ff;
   logic [QW-1:0] s4_qprod_ff, s4_tprod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_side_ff  <= s3_side_ff;
      s4_pprod_ff <= PW'(s3_pnum_ff) * PW'(P_RECIP);
      s4_qprod_ff <= QW'(s3_qnum_ff) * QW'(Q_RECIP);
      s4_tprod_ff <= QW'(s3_tnum_ff) * QW'(Q_RECIP);
   end

   // Each quotient is at most the value channel, so it fits the channel.
   logic [CB-1:0] p_quo, q_quo, t_quo;

   assign p_quo = s4_pprod_ff[P_SHIFT +: CB];
   assign q_quo = s4_qprod_ff[Q_SHIFT +: CB];
   assign t_quo = s4_tprod_ff[Q_SHIFT +: CB];

   // Stage 5: sector select; RGB is reported only for commands that make it.
   side_type      o_side;
   logic [CB-1:0] v_ch, red, green, blue;
   logic          rgb_en;

   always_comb begin
      o_side = s4_side_ff;
      v_ch   = o_side.req.val;
      rgb_en = (o_side.req.cmd == rgbhsv_pkg::CMD_TO_RGB) ||
               (o_side.req.cmd == rgbhsv_pkg::CMD_ADJUST);
      unique case (o_side.sector)
         3'd0:    begin red = v_ch;  green = t_quo; blue = p_quo; end
         3'd1:    begin red = q_quo; green = v_ch;  blue = p_quo; end
         3'd2:    begin red = p_quo; green = v_ch;  blue = t_quo; end
         3'd3:    begin red = p_quo; green = q_quo; blue = v_ch;  end
         3'd4:    begin red = t_quo; green = p_quo; blue = v_ch;  end
         default: begin red = v_ch;  green = p_quo; blue = q_quo; end
      endcase
   end

   logic                o_valid_ff;
   rgbhsv_pkg::rsp_type o_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      o_rsp_ff.red   <= rgb_en ? red   : '0;
      o_rsp_ff.green <= rgb_en ? green : '0;
      o_rsp_ff.blue  <= rgb_en ? blue  : '0;
      o_rsp_ff.hue   <= o_side.req.hue_res;
      o_rsp_ff.sat   <= o_side.req.sat_res;
      o_rsp_ff.val   <= o_side.req.val_res;
   end

   assign valid_out = o_valid_ff;
   assign rsp_out   = o_rsp_ff;

endmodule

### rtl/rgb_hsv_color_convert.sv
// ============================================================================
// RGB/HSV color converter, top level
// Converts RGB to HSV, HSV to RGB, or adjusts RGB through HSV gains.
// ============================================================================
//
//   Channel    Ports                              Handshake
//   ---------  ---------------------------------  ---------------------------
//   request    start, busy, req_*                 taken when start and !busy
//   response   rsp_valid, rsp_*                   one-cycle strobe, no stall
//   registers  csr_valid, csr_ready, csr_index,   written when valid and ready
//              csr_data
//
// The block is a fully pipelined datapath: a new item may be started in
// every clock cycle, and busy is never raised. The latency from accepting
// an item to its response is set by the two bit-per-stage dividers of the
// RGB to HSV section (ten stages each, for hue and saturation) plus the
// surrounding register stages, while the constant divisions of the HSV to
// RGB section take one multiply stage.
// The synchronous reset clears every valid bit and loads the default gains.
// The receiver cannot stall, so results simply flow off the end of the pipeline.
//
module rgb_hsv_color_convert (
   input  logic                                      clock,
   input  logic                                      reset,

   // Request channel.
   input  logic                                      start,
   output logic                                      busy,
   input  logic [rgbhsv_pkg::CMD_BITS-1:0]           req_cmd,
   input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]       req_red_in,
   input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]       req_green_in,
   input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]       req_blue_in,
   input  logic [rgbhsv_pkg::HUE_BITS-1:0]           req_hue_in,
   input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]       req_sat_in,
   input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]       req_val_in,

   // Response channel.
   output logic                                      rsp_valid,
   output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]       rsp_red_out,
   output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]       rsp_green_out,
   output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]       rsp_blue_out,
   output logic [rgbhsv_pkg::HUE_BITS-1:0]           rsp_hue_out,
   output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]       rsp_sat_out,
   output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]       rsp_val_out,

   // Register write channel.
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [rgbhsv_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [rgbhsv_pkg::GAIN_BITS-1:0]          csr_data
);

   localparam int CB = rgbhsv_pkg::CHANNEL_BITS;
   localparam int GB = rgbhsv_pkg::GAIN_BITS;
   localparam int PB = CB + GB;

   // The pipeline never holds an item back, so requests are always taken.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Gain registers. Writes to indexes beyond the list are dropped.
   logic [GB-1:0] sat_gain_ff, val_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_gain_ff <= GB'(rgbhsv_pkg::SAT_GAIN_RESET);
         val_gain_ff <= GB'(rgbhsv_pkg::VAL_GAIN_RESET);
      end else if (csr_valid) begin
         if (csr_index == rgbhsv_pkg::CSR_SAT_GAIN) begin
            sat_gain_ff <= csr_data;
         end
         if (csr_index == rgbhsv_pkg::CSR_VAL_GAIN) begin
            val_gain_ff <= csr_data;
         end
      end
   end

   // Input register stage.
   logic                  in_valid_ff;
   rgbhsv_pkg::pixel_type in_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff.cmd   <= req_cmd;
      in_item_ff.red   <= req_red_in;
      in_item_ff.green <= req_green_in;
      in_item_ff.blue  <= req_blue_in;
      in_item_ff.hue   <= req_hue_in;
      in_item_ff.sat   <= req_sat_in;
      in_item_ff.val   <= req_val_in;
   end

   // RGB to HSV. Every item passes through so that the latency is the same
   // for every command; the original HSV fields ride along for command 1.
   logic                     hsv_valid;
   rgbhsv_pkg::hsv_item_type hsv_item;

   rgbhsv_to_hsv u_to_hsv (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (in_valid_ff),
      .item_in   (in_item_ff),
      .valid_out (hsv_valid),
      .item_out  (hsv_item)
   );

   // Gain stage: scale saturation and value, saturating at full scale, and
   // pick what the RGB section converts and what the result reports.
   logic [PB-1:0] sat_prod, val_prod;
   logic [CB-1:0] sat_adj, val_adj;
   rgbhsv_pkg::rgb_req_type g_req;

   always_comb begin
      sat_prod = (PB'(hsv_item.sat) * PB'(sat_gain_ff)) >> rgbhsv_pkg::GAIN_FRAC;
      val_prod = (PB'(hsv_item.val) * PB'(val_gain_ff)) >> rgbhsv_pkg::GAIN_FRAC;
      sat_adj  = (sat_prod > PB'(rgbhsv_pkg::CMAX)) ? CB'(rgbhsv_pkg::CMAX) : sat_prod[CB-1:0];
      val_adj  = (val_prod > PB'(rgbhsv_pkg::CMAX)) ? CB'(rgbhsv_pkg::CMAX) : val_prod[CB-1:0];

      g_req.cmd = hsv_item.src.cmd;
      unique case (hsv_item.src.cmd)
         rgbhsv_pkg::CMD_TO_HSV: begin
            g_req.hue     = hsv_item.hue;
            g_req.sat     = hsv_item.sat;
            g_req.val     = hsv_item.val;
            g_req.hue_res = hsv_item.hue;
            g_req.sat_res = hsv_item.sat;
            g_req.val_res = hsv_item.val;
         end
         rgbhsv_pkg::CMD_TO_RGB: begin
            g_req.hue     = hsv_item.src.hue;
            g_req.sat     = hsv_item.src.sat;
            g_req.val     = hsv_item.src.val;
            g_req.hue_res = '0;
            g_req.sat_res = '0;
            g_req.val_res = '0;
         end
         rgbhsv_pkg::CMD_ADJUST: begin
            g_req.hue     = hsv_item.hue;
            g_req.sat     = sat_adj;
            g_req.val     = val_adj;
            g_req.hue_res = hsv_item.hue;
            g_req.sat_res = sat_adj;
            g_req.val_res = val_adj;
         end
         default: begin
            // The unused command reports all zeros.
            g_req.hue     = '0;
            g_req.sat     = '0;
            g_req.val     = '0;
            g_req.hue_res = '0;
            g_req.sat_res = '0;
            g_req.val_res = '0;
         end
      endcase
   end

   logic                    g_valid_ff;
   rgbhsv_pkg::rgb_req_type g_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else begin
         g_valid_ff <= hsv_valid;
      end
   end

   always_ff @(posedge clock) begin
      g_req_ff <= g_req;
   end

   // HSV to RGB, ending in the output register.
   logic                out_valid;
   rgbhsv_pkg::rsp_type out_rsp;

   rgbhsv_to_rgb u_to_rgb (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (g_valid_ff),
      .req_in    (g_req_ff),
      .valid_out (out_valid),
      .rsp_out   (out_rsp)
   );

   assign rsp_valid     = out_valid;
   assign rsp_red_out   = out_rsp.red;
   assign rsp_green_out = out_rsp.green;
   assign rsp_blue_out  = out_rsp.blue;
   assign rsp_hue_out   = out_rsp.hue;
   assign rsp_sat_out   = out_rsp.sat;
   assign rsp_val_out   = out_rsp.val;

endmodule

### test/rgb_hsv_color_convert_tb.sv
// ----------------------------------------------------------------------------
// RGB/HSV color converter testbench
// Drives converter commands through the start/busy request port, predicts
// every result in a small scoreboard, and checks each response strobe
// field by field while the gain registers move through several settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_hsv_color_convert_tb;
   import rgbhsv_pkg::*;

   // Codes that the package leaves unnamed: the spare command and a
   // register index past the end of the register list.
   localparam logic [CMD_BITS-1:0]       CMD_SPARE   = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NO_REG  = 4'd9;
   // Drain margin after the last result comes back.
   localparam int DRAIN_CYCLES  = 40;
   localparam int STALL_LIMIT   = 3000;
   localparam int ITEMS_PER_PHASE = 335;

   // The scoreboard keeps its own copy of the gain registers and a queue
   // of predicted pixels, oldest first.
   class color_scoreboard;
      rsp_type              pending_pixels[$];
      logic [GAIN_BITS-1:0] sat_gain;
      logic [GAIN_BITS-1:0] val_gain;
      int                   failures;

      function new();
         sat_gain = GAIN_BITS'(SAT_GAIN_RESET);
         val_gain = GAIN_BITS'(VAL_GAIN_RESET);
         failures = 0;
      endfunction

      function void write_gain(logic [CSR_INDEX_BITS-1:0] index,
                               logic [GAIN_BITS-1:0] data);
         if (index == CSR_SAT_GAIN) begin
            sat_gain = data;
         end else if (index == CSR_VAL_GAIN) begin
            val_gain = data;
         end
      endfunction

      function void rgb_to_hsv(longint unsigned r, longint unsigned g,
                               longint unsigned b, output longint unsigned h,
                               output longint unsigned s,
                               output longint unsigned v);
         longint unsigned top, bottom, delta, base, a, c, mag;
         top = r;
         bottom = r;
         if (g > top) top = g;
         if (b > top) top = b;
         if (g < bottom) bottom = g;
         if (b < bottom) bottom = b;
         delta = top - bottom;
         v = top;
         h = 0;
         s = 0;
         if (delta != 0) begin
            s = delta * CMAX / top;
            // Red wins a tie for the maximum, then green.
            if (r >= top) begin
               base = 0; a = g; c = b;
            end else if (g >= top) begin
               base = 2 * SEXT; a = b; c = r;
            end else begin
               base = 4 * SEXT; a = r; c = g;
            end
            if (a >= c) begin
               h = base + SEXT * (a - c) / delta;
            end else begin
               mag = SEXT * (c - a) / delta;
               h = (mag > base) ? base + FULL_TURN - mag : base - mag;
            end
         end
      endfunction

      function void hsv_to_rgb(longint unsigned h, longint unsigned s,
                               longint unsigned v, output longint unsigned r,
                               output longint unsigned g,
                               output longint unsigned b);
         longint unsigned sector, f, p, q, t;
         // Hues of a full turn or more wrap through the six sectors.
         sector = (h / SEXT) % 6;
         f = h % SEXT;
         p = v * (CMAX - s) / CMAX;
         q = v * (DEN - f * s) / DEN;
         t = v * (DEN - (SEXT - f) * s) / DEN;
         case (sector)
            0: begin r = v; g = t; b = p; end
            1: begin r = q; g = v; b = p; end
            2: begin r = p; g = v; b = t; end
            3: begin r = p; g = q; b = v; end
            4: begin r = t; g = p; b = v; end
            default: begin r = v; g = p; b = q; end
         endcase
      endfunction

      function longint unsigned scale_channel(longint unsigned x,
                                              longint unsigned gain);
         longint unsigned y;
         y = (x * gain) >> GAIN_FRAC;
         return (y > CMAX) ? CMAX : y;
      endfunction

      // Works out the pixel that an accepted command must produce.
      function void note_item(pixel_type px);
         longint unsigned r, g, b, h, s, v;
         rsp_type         want;
         r = 0; g = 0; b = 0; h = 0; s = 0; v = 0;
         case (px.cmd)
            CMD_TO_HSV: rgb_to_hsv(64'(px.red), 64'(px.green), 64'(px.blue),
                                   h, s, v);
            CMD_TO_RGB: hsv_to_rgb(64'(px.hue), 64'(px.sat), 64'(px.val),
                                   r, g, b);
            CMD_ADJUST: begin
               rgb_to_hsv(64'(px.red), 64'(px.green), 64'(px.blue), h, s, v);
               s = scale_channel(s, 64'(sat_gain));
               v = scale_channel(v, 64'(val_gain));
               hsv_to_rgb(h, s, v, r, g, b);
            end
            default: ;
         endcase
         want.red   = CHANNEL_BITS'(r);
         want.green = CHANNEL_BITS'(g);
         want.blue  = CHANNEL_BITS'(b);
         want.hue   = HUE_BITS'(h);
         want.sat   = CHANNEL_BITS'(s);
         want.val   = CHANNEL_BITS'(v);
         pending_pixels.push_back(want);
      endfunction

      function void check_field(string name, longint unsigned want,
                                longint unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_pixels.size() == 0) begin
            $error("response strobe with no item outstanding");
            failures++;
            return;
         end
         want = pending_pixels.pop_front();
         check_field("red_out",   64'(want.red),   64'(got.red));
         check_field("green_out", 64'(want.green), 64'(got.green));
         check_field("blue_out",  64'(want.blue),  64'(got.blue));
         check_field("hue_out",   64'(want.hue),   64'(got.hue));
         check_field("sat_out",   64'(want.sat),   64'(got.sat));
         check_field("val_out",   64'(want.val),   64'(got.val));
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [CMD_BITS-1:0]       req_cmd = '0;
   logic [CHANNEL_BITS-1:0]   req_red_in = '0;
   logic [CHANNEL_BITS-1:0]   req_green_in = '0;
   logic [CHANNEL_BITS-1:0]   req_blue_in = '0;
   logic [HUE_BITS-1:0]       req_hue_in = '0;
   logic [CHANNEL_BITS-1:0]   req_sat_in = '0;
   logic [CHANNEL_BITS-1:0]   req_val_in = '0;
   logic                      rsp_valid;
   logic [CHANNEL_BITS-1:0]   rsp_red_out;
   logic [CHANNEL_BITS-1:0]   rsp_green_out;
   logic [CHANNEL_BITS-1:0]   rsp_blue_out;
   logic [HUE_BITS-1:0]       rsp_hue_out;
   logic [CHANNEL_BITS-1:0]   rsp_sat_out;
   logic [CHANNEL_BITS-1:0]   rsp_val_out;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [GAIN_BITS-1:0]      csr_data = '0;

   color_scoreboard pixel_board = new();
   int              idle_percent = 0;
   int              quiet_cycles = 0;

   rgb_hsv_color_convert DUT (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_red_in(req_red_in), .req_green_in(req_green_in),
      .req_blue_in(req_blue_in), .req_hue_in(req_hue_in),
      .req_sat_in(req_sat_in), .req_val_in(req_val_in),
      .rsp_valid(rsp_valid), .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out), .rsp_blue_out(rsp_blue_out),
      .rsp_hue_out(rsp_hue_out), .rsp_sat_out(rsp_sat_out),
      .rsp_val_out(rsp_val_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Monitor. Inputs change only through nonblocking assignments at the
   // rising edge, so the values read here are the ones the block saw at
   // this same edge. Every handshake also feeds the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            pixel_board.note_item('{req_cmd, req_red_in, req_green_in,
                                    req_blue_in, req_hue_in, req_sat_in,
                                    req_val_in});
         end
         if (rsp_valid) begin
            pixel_board.check_result('{rsp_red_out, rsp_green_out,
                                       rsp_blue_out, rsp_hue_out,
                                       rsp_sat_out, rsp_val_out});
         end
         if (csr_valid && csr_ready) begin
            pixel_board.write_gain(csr_index, csr_data);
         end
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Presents one item and returns at the edge where it is taken. Before
   // that, each cycle is left idle with the phase's idle percentage.
   task automatic send_pixel(pixel_type px);
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_cmd      <= px.cmd;
      req_red_in   <= px.red;
      req_green_in <= px.green;
      req_blue_in  <= px.blue;
      req_hue_in   <= px.hue;
      req_sat_in   <= px.sat;
      req_val_in   <= px.val;
      do @(posedge clock); while (busy);
   endtask

   // Waits until every predicted pixel has come back, then lets the
   // pipeline run empty so a register write cannot touch an item in flight.
   task automatic drain_pipeline();
      start <= 1'b0;
      while (pixel_board.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The write strobe drops for one cycle after each write.
   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [GAIN_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random pixel. RGB content is skewed toward gray pixels, ties for the
   // maximum and full-scale channels, which steer the hue sector choice.
   function automatic pixel_type random_pixel();
      pixel_type px;
      int        pick;
      pick = $urandom_range(99);
      if (pick < 31)      px.cmd = CMD_TO_HSV;
      else if (pick < 62) px.cmd = CMD_TO_RGB;
      else if (pick < 96) px.cmd = CMD_ADJUST;
      else                px.cmd = CMD_SPARE;
      px.red   = CHANNEL_BITS'($urandom);
      px.green = CHANNEL_BITS'($urandom);
      px.blue  = CHANNEL_BITS'($urandom);
      case ($urandom_range(9))
         0: begin px.green = px.red; px.blue = px.red; end
         1: px.green = px.red;
         2: px.blue = px.green;
         3: px.blue = px.red;
         4: begin
            px.red   = $urandom_range(1) ? CHANNEL_BITS'(CMAX) : '0;
            px.green = $urandom_range(1) ? CHANNEL_BITS'(CMAX) : '0;
            px.blue  = $urandom_range(1) ? CHANNEL_BITS'(CMAX) : '0;
         end
         default: ;
      endcase
      // Mostly legal hues; sometimes any 13-bit value, to wrap the sectors.
      if ($urandom_range(9) == 0) px.hue = HUE_BITS'($urandom);
      else                        px.hue = HUE_BITS'($urandom_range(FULL_TURN - 1));
      px.sat = CHANNEL_BITS'($urandom);
      px.val = CHANNEL_BITS'($urandom);
      if ($urandom_range(7) == 0) px.sat = $urandom_range(1) ? CHANNEL_BITS'(CMAX) : '0;
      if ($urandom_range(7) == 0) px.val = $urandom_range(1) ? CHANNEL_BITS'(CMAX) : '0;
      return px;
   endfunction

   initial begin
      pixel_type directed[$];
      int        sat_setting[4];
      int        val_setting[4];
      int        phase_idle[4];

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at the reset gains: black, white, the primaries,
      // ties for the maximum, the red sector wrapping below zero degrees,
      // every hue sector, hues past a full turn, extreme saturation and
      // value, and the spare command, which must give an all-zero pixel.
      directed.push_back('{CMD_TO_HSV, 8'd0,   8'd0,   8'd0,   13'd0, 8'd0, 8'd0});
      directed.push_back('{CMD_TO_HSV, 8'd255, 8'd255, 8'd255, 13'd0, 8'd0, 8'd0});
      directed.push_back('{CMD_TO_HSV, 8'd255, 8'd0,   8'd0,   13'd0, 8'd0, 8'd0});
      directed.push_back('{CMD_TO_HSV, 8'd0,   8'd255, 8'd0,   13'd0, 8'd0, 8'd0});
      directed.push_back('{CMD_TO_HSV, 8'd0,   8'd0,   8'd255, 13'd0, 8'd0, 8'd0});
      directed.push_back('{CMD_TO_HSV, 8'd200, 8'd200, 8'd10,  13'd0, 8'd0, 8'd0});
      directed.push_back('{CMD_TO_HSV, 8'd9,   8'd200, 8'd200, 13'd0, 8'd0, 8'd0});
      directed.push_back('{CMD_TO_HSV, 8'd255, 8'd0,   8'd1,   13'd0, 8'd0, 8'd0});
      directed.push_back('{CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 13'd0,    8'd255, 8'd255});
      directed.push_back('{CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 13'd1000, 8'd255, 8'd255});
      directed.push_back('{CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 13'd2000, 8'd128, 8'd200});
      directed.push_back('{CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 13'd3000, 8'd255, 8'd100});
      directed.push_back('{CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 13'd4000, 8'd77,  8'd255});
      directed.push_back('{CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 13'd5759, 8'd255, 8'd255});
      directed.push_back('{CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 13'd5760, 8'd200, 8'd200});
      directed.push_back('{CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 13'd8191, 8'd255, 8'd255});
      directed.push_back('{CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 13'd1234, 8'd0,   8'd0});
      directed.push_back('{CMD_ADJUST, 8'd255, 8'd0,   8'd0,   13'd0, 8'd0, 8'd0});
      directed.push_back('{CMD_ADJUST, 8'd128, 8'd128, 8'd128, 13'd0, 8'd0, 8'd0});
      directed.push_back('{CMD_ADJUST, 8'd30,  8'd160, 8'd255, 13'd0, 8'd0, 8'd0});
      directed.push_back('{CMD_ADJUST, 8'd255, 8'd255, 8'd255, 13'd0, 8'd0, 8'd0});
      directed.push_back('{CMD_SPARE,  8'd255, 8'd255, 8'd255, 13'd8191, 8'd255,
                           8'd255});
      foreach (directed[i]) send_pixel(directed[i]);
      drain_pipeline();

      // A write past the register list must leave both gains alone.
      write_register(CSR_NO_REG, 10'h3FF);

      // Each phase sets the gains, then runs random items with its own
      // amount of sender idling; two phases never idle at all, since the
      // receiver cannot hold results off.
      sat_setting = '{0, 1023, 256, -1};
      val_setting = '{1023, 0, 256, -1};
      phase_idle  = '{0, 52, 0, 28};
      for (int phase = 0; phase < 4; phase++) begin
         drain_pipeline();
         write_register(CSR_SAT_GAIN, sat_setting[phase] < 0 ?
                        GAIN_BITS'($urandom) : GAIN_BITS'(sat_setting[phase]));
         write_register(CSR_VAL_GAIN, val_setting[phase] < 0 ?
                        GAIN_BITS'($urandom) : GAIN_BITS'(val_setting[phase]));
         idle_percent = phase_idle[phase];
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_pixel(random_pixel());
      end

      drain_pipeline();
      if (pixel_board.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/rgbhsv_pkg.sv
rtl/rgbhsv_div.sv
rtl/rgbhsv_to_hsv.sv
rtl/rgbhsv_to_rgb.sv
rtl/rgb_hsv_color_convert.sv
test/rgb_hsv_color_convert_tb.sv
